### rtl/core/srsc_pkg.sv
// Shared widths and side codes for the square ring spiral mapper.
`timescale 1ns / 1ps

package srsc_pkg;

    localparam int X_BITS = 25;
    localparam int Z_BITS = 25;
    localparam int R_BITS = 24;

    typedef logic [1:0] side_t;

    localparam side_t SIDE_BOTTOM = 2'd0;
    localparam side_t SIDE_RIGHT  = 2'd1;
    localparam side_t SIDE_TOP    = 2'd2;
    localparam side_t SIDE_LEFT   = 2'd3;

endpackage

### rtl/core/srsc_sqrt_cell.sv
// One digit cell of the pipelined integer square root: resolves one root bit per stage.
`timescale 1ns / 1ps

module srsc_sqrt_cell #(
    parameter int SW   = 25,
    parameter int STEP = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2*SW-1:0]     in_rad,
    input  logic [SW+1:0]       in_rem,
    input  logic [SW-1:0]       in_root,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2*SW-1:0]     out_rad,
    output logic [SW+1:0]       out_rem,
    output logic [SW-1:0]       out_root
);

    localparam int PW = 2 * SW;
    localparam int RW = SW + 2;
    localparam int CW = RW + 2;

    logic          valid_reg;
    logic [PW-1:0] rad_reg;
    logic [RW-1:0] rem_reg;
    logic [SW-1:0] root_reg;

    logic [1:0]    pair;
    logic [CW-1:0] cur;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic          take;
    logic [RW-1:0] rem_next;
    logic [SW-1:0] root_next;

    // next two radicand bits, most significant pair first
    assign pair  = in_rad[PW-1-2*STEP -: 2];
    assign cur   = {in_rem, pair};
    assign trial = CW'({in_root, 2'b01});
    assign take  = (cur >= trial);
    assign diff  = cur - trial;

    assign rem_next  = take ? RW'(diff) : RW'(cur);
    assign root_next = {in_root[SW-2:0], take};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rad_reg  <= in_rad;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

### rtl/core/srsc_ring_map.sv
// Four-stage pipeline turning m and floor(sqrt(m)) into ring radius and x/z position.
`timescale 1ns / 1ps

module srsc_ring_map #(
    parameter int SW = 25,
    parameter int MW = 49
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [MW-1:0]                       in_m,
    input  logic [SW-1:0]                       in_root,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [srsc_pkg::X_BITS-1:0]  out_x,
    output logic signed [srsc_pkg::Z_BITS-1:0]  out_z,
    output logic [srsc_pkg::R_BITS-1:0]         out_r
);

    import srsc_pkg::*;

    localparam int AW = SW + 2;
    localparam int CW = SW + 2;

    logic rdy1, rdy2, rdy3, rdy4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: ring number r = (s + 1) / 2
    logic [SW-1:0]   r1_next, r1_reg;
    logic [MW-1:0]   m1_reg;
    logic [SW:0]     s_inc;

    // stage 2: r * (r - 1)
    logic [2*SW-1:0] prod2_next, prod2_reg;
    logic [SW-1:0]   r2_reg;
    logic [MW-1:0]   m2_reg;

    // stage 3: offset into ring, wrapped at 8r
    logic [MW-1:0]   d3;
    logic [MW-1:0]   eight_r3;
    logic [AW-1:0]   a3_next, a3_reg;
    logic [SW-1:0]   r3_reg;

    // stage 4: side select and coordinates
    logic [AW-1:0]   two_r, four_r, six_r;
    logic [AW-1:0]   t4;
    side_t           side4;
    logic signed [CW-1:0] rs, ts, xs, zs;
    logic signed [X_BITS-1:0] x4_next, x4_reg;
    logic signed [Z_BITS-1:0] z4_next, z4_reg;
    logic [R_BITS-1:0]        r4_next, r4_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign s_inc   = {1'b0, in_root} + (SW+1)'(1);
    assign r1_next = s_inc[SW:1];

    assign prod2_next = (2*SW)'(r1_reg) * (2*SW)'(r1_reg - SW'(1));

    // d lies in [1, 8r]; only the full count 8r wraps to zero
    assign d3       = m2_reg - MW'({prod2_reg, 2'b00});
    assign eight_r3 = MW'({r2_reg, 3'b000});
    assign a3_next  = (d3 == eight_r3) ? '0 : AW'(d3);

    assign two_r  = AW'({r3_reg, 1'b0});
    assign four_r = AW'({r3_reg, 2'b00});
    assign six_r  = four_r + two_r;

    always_comb begin
        priority if (a3_reg < two_r) begin
            side4 = SIDE_BOTTOM;
            t4    = a3_reg;
        end else if (a3_reg < four_r) begin
            side4 = SIDE_RIGHT;
            t4    = a3_reg - two_r;
        end else if (a3_reg < six_r) begin
            side4 = SIDE_TOP;
            t4    = a3_reg - four_r;
        end else begin
            side4 = SIDE_LEFT;
            t4    = a3_reg - six_r;
        end
    end

    assign rs = signed'(CW'(r3_reg));
    assign ts = signed'(CW'(t4));

    always_comb begin
        unique case (side4)
            SIDE_BOTTOM: begin
                xs = ts - rs;
                zs = -rs;
            end
            SIDE_RIGHT: begin
                xs = rs;
                zs = ts - rs;
            end
            SIDE_TOP: begin
                xs = rs - ts;
                zs = rs;
            end
            default: begin
                xs = -rs;
                zs = rs - ts;
            end
        endcase
    end

    assign x4_next = X_BITS'(xs);
    assign z4_next = Z_BITS'(zs);
    assign r4_next = R_BITS'(r3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            r1_reg <= r1_next;
            m1_reg <= in_m;
        end
        if (rdy2 && v1_reg) begin
            prod2_reg <= prod2_next;
            r2_reg    <= r1_reg;
            m2_reg    <= m1_reg;
        end
        if (rdy3 && v2_reg) begin
            a3_reg <= a3_next;
            r3_reg <= r2_reg;
        end
        if (rdy4 && v3_reg) begin
            x4_reg <= x4_next;
            z4_reg <= z4_next;
            r4_reg <= r4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_x     = x4_reg;
    assign out_z     = z4_reg;
    assign out_r     = r4_reg;

endmodule

### rtl/core/square_ring_spiral_coordinates.sv
// Top level: spiral index to square-ring grid position, one transaction per cycle while the output accepts results.
`timescale 1ns / 1ps

// Maps an index n to a position on square rings around the origin, returning x, z
// and the ring radius r. It takes one transaction every cycle while the output side
// accepts results, and returns one result per transaction in order. The pipeline is
// a chain of square-root digit cells, one per root bit, followed by four mapping
// stages (ring number, r*(r-1), ring offset, side/coordinates). Both channels may
// stall at any time; every stage holds its data until the next one frees, and the
// last stage is the output register.
module square_ring_spiral_coordinates #(
    parameter int INDEX_BITS = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [INDEX_BITS-1:0]               s_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [srsc_pkg::X_BITS-1:0]  m_x_offset,
    output logic signed [srsc_pkg::Z_BITS-1:0]  m_z_offset,
    output logic [srsc_pkg::R_BITS-1:0]         m_ring_radius
);

    import srsc_pkg::*;

    localparam int MW = INDEX_BITS + 1;
    localparam int SW = (MW + 1) / 2;
    localparam int PW = 2 * SW;
    localparam int RW = SW + 2;

    logic          cv [0:SW];
    logic          cr [0:SW];
    logic [PW-1:0] crad [0:SW];
    logic [RW-1:0] crem [0:SW];
    logic [SW-1:0] croot [0:SW];

    logic [MW-1:0] m_in;

    assign m_in     = MW'(s_index) + MW'(1);
    assign cv[0]    = s_valid;
    assign s_ready  = cr[0];
    assign crad[0]  = PW'(m_in);
    assign crem[0]  = '0;
    assign croot[0] = '0;

    for (genvar i = 0; i < SW; i++) begin : g_cell
        srsc_sqrt_cell #(
            .SW   (SW),
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_rad    (crad[i]),
            .in_rem    (crem[i]),
            .in_root   (croot[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_rad   (crad[i+1]),
            .out_rem   (crem[i+1]),
            .out_root  (croot[i+1])
        );
    end

    srsc_ring_map #(
        .SW (SW),
        .MW (MW)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cv[SW]),
        .in_ready  (cr[SW]),
        .in_m      (crad[SW][MW-1:0]),
        .in_root   (croot[SW]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_x_offset),
        .out_z     (m_z_offset),
        .out_r     (m_ring_radius)
    );

    // root check at the end of the digit chain: s*s <= m < (s+1)*(s+1)
    localparam int QW = 2 * SW + 2;

    logic [QW-1:0] chk_s, chk_m;

    assign chk_s = QW'(croot[SW]);
    assign chk_m = QW'(crad[SW][MW-1:0]);

    a_root_low: assert property (@(posedge aclk) disable iff (!aresetn)
        cv[SW] |-> (chk_s * chk_s <= chk_m))
        else $error("square root too large");

    a_root_high: assert property (@(posedge aclk) disable iff (!aresetn)
        cv[SW] |-> ((chk_s + QW'(1)) * (chk_s + QW'(1)) > chk_m))
        else $error("square root too small");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
